// ===== hw/rtl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the IPv4 flow pair counter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned TOTAL_W     = $clog2(TABLE_DEPTH + 1);

  // Frame fields
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TYPE_W   = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned KEY_W    = 2 * ADDR_W;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned POS_MAX  = (2 ** POS_W) - 1;
  localparam logic [TYPE_W-1:0] IPV4_TYPE = 16'h0800;

  // Byte offsets within the frame
  localparam int unsigned POS_TYPE_HI   = 12;
  localparam int unsigned POS_TYPE_LO   = 13;
  localparam int unsigned POS_SRC_FIRST = 26;
  localparam int unsigned POS_SRC_LAST  = 29;
  localparam int unsigned POS_DST_FIRST = 30;
  localparam int unsigned POS_DST_LAST  = 33;

  // Queue between parser and table engine
  localparam int unsigned QUEUE_DEPTH = 2;

  // Result beat layout
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OUT_BITS   = SLOT_W + COUNT_WIDTH + TOTAL_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT      = 3'd0,
    STAT_NEW      = 3'd1,
    STAT_NOT_IPV4 = 3'd2,
    STAT_SHORT    = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    JOB_LOOKUP,
    JOB_NOT_IPV4,
    JOB_SHORT
  } job_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    logic [KEY_W-1:0] key;
  } job_t;

  typedef struct packed {
    status_e                status;
    logic [SLOT_W-1:0]      slot;
    logic [COUNT_WIDTH-1:0] refs;
    logic [TOTAL_W-1:0]     total;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpc_ram.sv =====
// ----------------------------------------------------------------------------
// fpc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fpc_front.sv =====
// ----------------------------------------------------------------------------
// fpc_front
// Frame parser: tracks byte position, captures EtherType and IPv4 addresses,
// and classifies each frame at its last byte into a job for the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [fpc_pkg::BYTE_W-1:0]  byte_i,
  input  logic                        last_i,
  input  logic                        full_i,
  output logic                        push_o,
  output fpc_pkg::job_t               job_o
);

  import fpc_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [TYPE_W-1:0] type_q, type_d;
  logic [ADDR_W-1:0] src_q, src_d;
  logic [ADDR_W-1:0] dst_q, dst_d;
  logic              accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    pos_d       = pos_q;
    type_d      = type_q;
    src_d       = src_q;
    dst_d       = dst_q;
    push_o      = 1'b0;
    job_o.kind  = JOB_SHORT;
    if (accept) begin
      if (pos_q inside {POS_TYPE_HI, POS_TYPE_LO}) begin
        type_d = {type_q[TYPE_W-BYTE_W-1:0], byte_i};
      end else if (pos_q inside {[POS_SRC_FIRST:POS_SRC_LAST]}) begin
        src_d = {src_q[ADDR_W-BYTE_W-1:0], byte_i};
      end else if (pos_q inside {[POS_DST_FIRST:POS_DST_LAST]}) begin
        dst_d = {dst_q[ADDR_W-BYTE_W-1:0], byte_i};
      end
      if (last_i) begin
        push_o = 1'b1;
        pos_d  = '0;
        // classify on the length including this beat
        if (pos_q < POS_TYPE_LO) begin
          job_o.kind = JOB_SHORT;
        end else if (type_d != IPV4_TYPE) begin
          job_o.kind = JOB_NOT_IPV4;
        end else if (pos_q < POS_DST_LAST) begin
          job_o.kind = JOB_SHORT;
        end else begin
          job_o.kind = JOB_LOOKUP;
        end
      end else if (pos_q != POS_W'(POS_MAX)) begin
        pos_d = pos_q + 1'b1;
      end
    end
    job_o.key = {src_d, dst_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      type_q <= '0;
      src_q  <= '0;
      dst_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      type_q <= type_d;
      src_q  <= src_d;
      dst_q  <= dst_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpc_queue.sv =====
// ----------------------------------------------------------------------------
// fpc_queue
// Short job queue between the frame parser and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fpc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fpc_pkg::job_t job_o
);

  import fpc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpc_back.sv =====
// ----------------------------------------------------------------------------
// fpc_back
// Table engine: scans the pair table one slot a cycle, counts hits, inserts
// misses into the lowest free slot while one is left and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  fpc_pkg::job_t    job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fpc_pkg::result_t out_o
);

  import fpc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [SLOT_W-1:0]      LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

  logic [1:0]             state_q, state_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic                   issue_q, issue_d;
  logic                   chk_q, chk_d;
  logic [SLOT_W-1:0]      chk_idx_q, chk_idx_d;
  logic                   free_found_q, free_found_d;
  logic [SLOT_W-1:0]      free_idx_q, free_idx_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [TOTAL_W-1:0]     total_q, total_d;
  result_t                res_q, res_d;
  logic                   out_vld_q, out_vld_d;
  result_t                out_q, out_d;

  logic [KEY_W-1:0]       key_rd;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic                   key_we, cnt_we;
  logic [SLOT_W-1:0]      wr_slot;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic                   entry_vld, hit, any_free;
  logic [SLOT_W-1:0]      pick_free;

  fpc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_slot),
    .wdata_i (key_q),
    .raddr_i (idx_q),
    .rdata_o (key_rd)
  );

  fpc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (wr_slot),
    .wdata_i (cnt_wdata),
    .raddr_i (idx_q),
    .rdata_o (cnt_rd)
  );

  assign entry_vld = valid_q[chk_idx_q];
  assign hit       = chk_q && entry_vld && (key_rd == key_q);
  assign any_free  = free_found_q || !entry_vld;
  assign pick_free = free_found_q ? free_idx_q : chk_idx_q;

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    idx_d        = idx_q;
    issue_d      = issue_q;
    chk_d        = 1'b0;
    chk_idx_d    = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    total_d      = total_q;
    res_d        = res_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_d        = out_q;
    pop_o        = 1'b0;
    key_we       = 1'b0;
    cnt_we       = 1'b0;
    wr_slot      = chk_idx_q;
    cnt_wdata    = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          case (job_i.kind)
            JOB_LOOKUP: begin
              key_d        = job_i.key;
              idx_d        = '0;
              issue_d      = 1'b1;
              free_found_d = 1'b0;
              state_d      = S_SCAN;
            end
            JOB_NOT_IPV4: begin
              res_d   = '{status: STAT_NOT_IPV4, slot: '0, refs: '0, total: total_q};
              state_d = S_RESULT;
            end
            default: begin
              res_d   = '{status: STAT_SHORT, slot: '0, refs: '0, total: total_q};
              state_d = S_RESULT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one slot read a cycle; its data is checked in the next cycle
        chk_d = issue_q;
        if (issue_q) begin
          if (idx_q == LAST_SLOT) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (hit) begin
          cnt_we  = 1'b1;
          res_d   = '{status: STAT_HIT, slot: chk_idx_q, refs: cnt_wdata, total: total_q};
          state_d = S_RESULT;
        end else if (chk_q) begin
          if (!entry_vld && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = chk_idx_q;
          end
          if (chk_idx_q == LAST_SLOT) begin
            state_d = S_RESULT;
            if (any_free) begin
              // insert into the lowest free slot with a count of one
              key_we             = 1'b1;
              cnt_we             = 1'b1;
              wr_slot            = pick_free;
              cnt_wdata          = COUNT_WIDTH'(1);
              valid_d[pick_free] = 1'b1;
              total_d            = total_q + 1'b1;
              res_d = '{status: STAT_NEW, slot: pick_free,
                        refs: COUNT_WIDTH'(1), total: total_q + 1'b1};
            end else begin
              res_d = '{status: STAT_FULL, slot: '0, refs: '0, total: total_q};
            end
          end
        end
      end

      S_RESULT: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issue_q      <= 1'b0;
      chk_q        <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      total_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      chk_q        <= chk_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
      total_q      <= total_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    idx_q      <= idx_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4_flow_pair_counter_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_flow_pair_counter_core
// Counts IPv4 source/destination address pairs seen in Ethernet II frames.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload (lowest bit first)                   Beat
//  s_axis    in   tdata: frame_byte; tlast: frame_last         one frame byte
//  m_axis    out  tuser: frame_status;                          one per frame
//                 tdata: flow_slot, pair_refs, distinct_pairs
//
//  Frame bytes are taken one a cycle while the job queue has room.
//  A frame that needs a table lookup occupies the table engine while it
//  scans, one slot read per cycle from the key RAM (a hit ends the scan
//  early); other frames go straight from idle to the result state.
//  Reset empties the table at once through per-slot valid bits.
//  A stalled m_axis holds one result; the queue keeps taking frames until
//  it fills, then s_axis_tready drops.
//
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_flow_pair_counter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // frame_byte
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fpc_pkg::BYTE_W-1:0]        s_axis_tdata,
  input  logic                              s_axis_tlast,
  // flow_slot, pair_refs, distinct_pairs (zero padded to whole bytes)
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fpc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // frame_status
  output logic [fpc_pkg::STATUS_W-1:0]      m_axis_tuser
);

  import fpc_pkg::*;

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_valid;
  job_t        push_job;
  job_t        head_job;
  result_t     result;

  // Parser: classify each frame at its last beat
  fpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .full_i  (q_full),
    .push_o  (q_push),
    .job_o   (push_job)
  );

  // Decouple parser from the table engine
  fpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // Table engine with its output register
  fpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  // Pack the result beat, slot in the lowest bits
  assign m_axis_tdata = OUT_DATA_W'({result.total, result.refs, result.slot});
  assign m_axis_tuser = result.status;

`ifndef NO_ASSERTIONS
  // Parser never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Engine only pops a job that is there
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // Every accepted last beat produces a job
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |-> q_push)
    else $error("frame end without job");

  // Rejected frames (not IPv4, short or table full) report no slot and no count
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STAT_NOT_IPV4 || m_axis_tuser == STAT_SHORT ||
     m_axis_tuser == STAT_FULL)) |-> (result.slot == '0 && result.refs == '0))
    else $error("rejected frame carries slot or count");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_ipv4_flow_pair_counter_core.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_flow_pair_counter_core
// Self-checking bench for the IPv4 flow pair counter: frames go in one byte
// per beat, a local copy of the pair table predicts every frame result, and
// each result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ipv4_flow_pair_counter_core;
  import fpc_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    bit                drain;  // hold this beat until every result is back
  } frame_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  ipv4_flow_pair_counter_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Stimulus and bookkeeping
  frame_beat_t    frame_beats_q[$];
  result_t        expected_results_q[$];
  logic [63:0]    pair_pool[$];  // address pairs handed out so far
  int             stim_total     = 0;
  int             accepted_beats = 0;
  int             faults         = 0;
  longint         cycle_count    = 0;
  longint         cycle_limit    = 64'd100_000_000;

  // Local copy of the parser state and the pair table
  logic [POS_W-1:0]       byte_pos  = '0;
  logic [TYPE_W-1:0]      eth_type  = '0;
  logic [ADDR_W-1:0]      src_addr  = '0;
  logic [ADDR_W-1:0]      dst_addr  = '0;
  logic [KEY_W-1:0]       flow_key  [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] flow_refs [TABLE_DEPTH];
  bit                     flow_used [TABLE_DEPTH];
  logic [TOTAL_W-1:0]     pair_count = '0;

  result_t obs_result;
  result_t due_result;

  // Idle pattern: sender-light/receiver-heavy, then swapped, then none
  int load_phase;
  int tx_idle_pct;
  int rx_idle_pct;
  assign load_phase  = (stim_total == 0) ? 0 :
                       ((accepted_beats * 3 / stim_total) > 2 ? 2 :
                        accepted_beats * 3 / stim_total);
  assign tx_idle_pct = (load_phase == 0) ? 12 : (load_phase == 1) ? 67 : 0;
  assign rx_idle_pct = (load_phase == 0) ? 67 : (load_phase == 1) ? 12 : 0;

  // Advance the local parser by one accepted byte; on the final byte of a
  // frame, classify it, update the table and queue the expected result.
  task automatic tally_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
    int               len;
    int               free_slot;
    bit               found;
    logic [KEY_W-1:0] key;
    result_t          res;
    if (byte_pos == POS_TYPE_HI || byte_pos == POS_TYPE_LO)
      eth_type = {eth_type[7:0], b};
    else if (byte_pos >= POS_SRC_FIRST && byte_pos <= POS_SRC_LAST)
      src_addr = {src_addr[23:0], b};
    else if (byte_pos >= POS_DST_FIRST && byte_pos <= POS_DST_LAST)
      dst_addr = {dst_addr[23:0], b};

    if (!last) begin
      // position sticks at its top value on long frames
      if (byte_pos != POS_MAX[POS_W-1:0]) byte_pos++;
      return;
    end

    len = int'(byte_pos) + 1;
    res = '0;
    if (len < POS_TYPE_LO + 1) begin
      res.status = STAT_SHORT;
    end else if (eth_type != IPV4_TYPE) begin
      res.status = STAT_NOT_IPV4;
    end else if (len < POS_DST_LAST + 1) begin
      res.status = STAT_SHORT;
    end else begin
      key       = {src_addr, dst_addr};
      free_slot = -1;
      found     = 1'b0;
      for (int i = 0; i < TABLE_DEPTH && !found; i++) begin
        if (flow_used[i]) begin
          if (flow_key[i] == key) begin
            found = 1'b1;
            if (flow_refs[i] != '1) flow_refs[i]++;
            res.status = STAT_HIT;
            res.slot   = i[SLOT_W-1:0];
            res.refs   = flow_refs[i];
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (!found) begin
        if (free_slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          flow_key[free_slot]  = key;
          flow_refs[free_slot] = COUNT_WIDTH'(1);
          flow_used[free_slot] = 1'b1;
          if (pair_count < TABLE_DEPTH) pair_count++;
          res.status = STAT_NEW;
          res.slot   = free_slot[SLOT_W-1:0];
          res.refs   = COUNT_WIDTH'(1);
        end
      end
    end
    res.total = pair_count;
    expected_results_q.push_back(res);
    byte_pos = '0;
  endtask

  // Queue one frame of len bytes with the given EtherType and addresses;
  // every other byte is random.
  task automatic add_frame(input int len, input logic [TYPE_W-1:0] etype,
                           input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                           input bit drain);
    frame_beat_t beat;
    for (int i = 0; i < len; i++) begin
      beat.data = BYTE_W'($urandom_range(255));
      if (i == POS_TYPE_HI) beat.data = etype[15:8];
      if (i == POS_TYPE_LO) beat.data = etype[7:0];
      if (i >= POS_SRC_FIRST && i <= POS_SRC_LAST)
        beat.data = src[8*(POS_SRC_LAST-i) +: 8];
      if (i >= POS_DST_FIRST && i <= POS_DST_LAST)
        beat.data = dst[8*(POS_DST_LAST-i) +: 8];
      beat.last  = (i == len - 1);
      beat.drain = drain && (i == 0);
      frame_beats_q.push_back(beat);
    end
  endtask

  // Sender: hold a beat until taken, drop tvalid on idle cycles, and wait
  // for the result queue to empty before a drain-marked beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        tally_frame_byte(s_axis_tdata, s_axis_tlast);
        void'(frame_beats_q.pop_front());
        accepted_beats++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (frame_beats_q.size() != 0 &&
            !(frame_beats_q[0].drain && expected_results_q.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= frame_beats_q[0].data;
          s_axis_tlast  <= frame_beats_q[0].last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      obs_result.status = status_e'(m_axis_tuser);
      obs_result.slot   = m_axis_tdata[SLOT_W-1:0];
      obs_result.refs   = m_axis_tdata[SLOT_W +: COUNT_WIDTH];
      obs_result.total  = m_axis_tdata[SLOT_W+COUNT_WIDTH +: TOTAL_W];
      if (expected_results_q.size() == 0) begin
        if (faults < 10)
          $display("[%0d] result beat with nothing pending: status %0d slot %0d refs %0d total %0d",
                   cycle_count, obs_result.status, obs_result.slot, obs_result.refs,
                   obs_result.total);
        faults++;
      end else begin
        due_result = expected_results_q.pop_front();
        if (obs_result.status !== due_result.status || obs_result.slot !== due_result.slot ||
            obs_result.refs !== due_result.refs || obs_result.total !== due_result.total) begin
          if (faults < 10)
            $display("[%0d] mismatch: want status %0d slot %0d refs %0d total %0d, got %0d %0d %0d %0d",
                     cycle_count, due_result.status, due_result.slot, due_result.refs,
                     due_result.total, obs_result.status, obs_result.slot, obs_result.refs,
                     obs_result.total);
          faults++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("FAIL ipv4_flow_pair_counter_core");
      $finish;
    end
  end

  initial begin
    int               roll;
    int               len;
    int               random_bytes;
    int               frame_no;
    logic [TYPE_W-1:0] etype;
    logic [63:0]      pair;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    addr_a = $urandom();
    addr_b = $urandom();

    // Directed frames: length boundaries, wrong types, address extremes,
    // repeats, swapped pairs and frames past the saturating position.
    add_frame(1,  IPV4_TYPE, '0, '0, 1'b0);                    // lone byte
    add_frame(13, IPV4_TYPE, '0, '0, 1'b0);                    // no EtherType yet
    add_frame(14, IPV4_TYPE, '0, '0, 1'b0);                    // IPv4, header cut
    add_frame(33, IPV4_TYPE, '0, '0, 1'b0);                    // one byte short
    add_frame(14, 16'h86DD, '0, '0, 1'b0);                     // other type, minimal
    add_frame(70, IPV4_TYPE ^ 16'h0001, '0, '0, 1'b0);         // near-miss type, long
    add_frame(34, IPV4_TYPE, '0, '0, 1'b0);                    // new, all-zero pair
    add_frame(34, IPV4_TYPE, '1, '1, 1'b0);                    // new, all-ones pair
    add_frame(64, IPV4_TYPE, '0, '0, 1'b0);                    // hit
    add_frame(90, IPV4_TYPE, '1, '1, 1'b0);                    // hit, very long
    add_frame(34, IPV4_TYPE, addr_a, addr_b, 1'b0);
    add_frame(34, IPV4_TYPE, addr_b, addr_a, 1'b0);            // swapped is distinct
    add_frame(40, IPV4_TYPE, addr_a, addr_b, 1'b1);            // hit after a drain
    pair_pool.push_back('0);
    pair_pool.push_back('1);
    pair_pool.push_back({addr_a, addr_b});
    pair_pool.push_back({addr_b, addr_a});

    // Random frames, mostly well-formed IPv4 with a pool of repeating pairs,
    // until the whole stimulus reaches its byte budget.
    random_bytes = frame_beats_q.size();
    frame_no     = 0;
    while (random_bytes < 1350) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        len   = $urandom_range(1, POS_DST_LAST);
        etype = ($urandom_range(1) != 0) ? IPV4_TYPE : TYPE_W'($urandom());
        add_frame(len, etype, $urandom(), $urandom(), frame_no % 40 == 0);
      end else if (roll < 16) begin
        len   = $urandom_range(POS_TYPE_LO + 1, 70);
        etype = ($urandom_range(1) != 0) ? TYPE_W'($urandom())
                                         : IPV4_TYPE ^ (16'h1 << $urandom_range(15));
        if (etype == IPV4_TYPE) etype = etype ^ 16'h8000;
        add_frame(len, etype, $urandom(), $urandom(), frame_no % 40 == 0);
      end else begin
        len = ($urandom_range(9) != 0) ? $urandom_range(POS_DST_LAST + 1, 44)
                                       : $urandom_range(45, 96);
        if ($urandom_range(99) < 55) begin
          if ($urandom_range(99) < 30)
            pair = pair_pool[$urandom_range(pair_pool.size() - 1)] ^
                   (64'h1 << $urandom_range(63));
          else
            pair = {$urandom(), $urandom()};
          pair_pool.push_back(pair);
        end else begin
          pair = pair_pool[$urandom_range(pair_pool.size() - 1)];
        end
        add_frame(len, IPV4_TYPE, pair[63:32], pair[31:0], frame_no % 40 == 0);
      end
      random_bytes += len;
      frame_no++;
    end

    stim_total  = frame_beats_q.size();
    cycle_limit = longint'(stim_total) * 150 + 50_000;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (frame_beats_q.size() != 0 || expected_results_q.size() != 0)
      @(posedge clk_i);
    // let any stray result beat surface
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);

    if (faults == 0 && expected_results_q.size() == 0) begin
      $display("PASS ipv4_flow_pair_counter_core");
    end else begin
      $display("FAIL ipv4_flow_pair_counter_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
